// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files of the escape decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: assertion failed");
// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`endif
`endif

// ----- src/bed_pkg.sv -----
// Types, codes and helper functions of the backslash escape decoder.
package bed_pkg;

    // Input transfer: one raw byte of the escaped string.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_t;

    // Result transfer: one decoded byte or one error report.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } out_t;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_TRAILING = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_BADHEX   = 3'd4;

    // Characters of the escape syntax
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_S         = 8'h73;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Value of a hex digit in bits [3:0]; bit 4 set when the byte is no hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end
        return v;
    endfunction

endpackage

// ----- src/bed_in_reg.sv -----
// Input register stage of the escape decoder.
module bed_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bed_pkg::in_t   s_data,
    output logic           item_valid,
    output bed_pkg::in_t   item,
    input  logic           item_take
);
    import bed_pkg::*;

    logic valid_reg;
    logic valid_next;
    in_t  data_reg;

    // Accept whenever the stage is empty or its item leaves this cycle.
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload on each input transfer.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// ----- src/bed_core.sv -----
// Escape decoding state machine: one byte per cycle while results find room, at most one result.
`include "assert_macros.svh"
module bed_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           item_valid,
    input  bed_pkg::in_t   item,
    output logic           item_take,
    input  logic           res_space,
    output logic           res_valid,
    output bed_pkg::out_t  res
);
    import bed_pkg::*;

    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_ESCAPE = 2'd1;
    localparam logic [1:0] PH_HEX    = 2'd2;
    localparam logic [1:0] PH_DROP   = 2'd3;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] high_nibble_reg;
    logic [3:0] high_nibble_next;
    logic [2:0] error_code_reg;
    logic [2:0] error_code_next;

    logic [4:0] hv;
    logic       is_hex;
    logic       eos;
    logic       has_res;
    out_t       res_c;

    assign hv     = hex_value(item.in_byte);
    assign is_hex = !hv[4];
    assign eos    = item.end_of_string;

    // Decode the current byte against the escape phase.
    always_comb begin
        has_res          = 1'b0;
        res_c            = '{out_byte: 8'h00, status: ST_OK, last: 1'b0};
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        error_code_next  = error_code_reg;
        unique case (phase_reg)
            PH_NORMAL: begin
                if (item.in_byte == CH_BACKSLASH) begin
                    if (eos) begin
                        has_res      = 1'b1;
                        res_c.status = ST_TRAILING;
                        res_c.last   = 1'b1;
                    end else begin
                        phase_next = PH_ESCAPE;
                    end
                end else begin
                    has_res        = 1'b1;
                    res_c.out_byte = item.in_byte;
                    res_c.last     = eos;
                end
            end
            PH_ESCAPE: begin
                if (is_hex) begin
                    if (eos) begin
                        has_res      = 1'b1;
                        res_c.status = ST_MISSING;
                        res_c.last   = 1'b1;
                        phase_next   = PH_NORMAL;
                    end else begin
                        high_nibble_next = hv[3:0];
                        phase_next       = PH_HEX;
                    end
                end else if (item.in_byte == CH_BACKSLASH || item.in_byte == CH_T ||
                             item.in_byte == CH_N || item.in_byte == CH_S) begin
                    has_res    = 1'b1;
                    res_c.last = eos;
                    phase_next = PH_NORMAL;
                    if (item.in_byte == CH_T) begin
                        res_c.out_byte = CH_TAB;
                    end else if (item.in_byte == CH_N) begin
                        res_c.out_byte = CH_NEWLINE;
                    end else if (item.in_byte == CH_S) begin
                        res_c.out_byte = CH_SPACE;
                    end else begin
                        res_c.out_byte = CH_BACKSLASH;
                    end
                end else if (eos) begin
                    has_res      = 1'b1;
                    res_c.status = ST_UNKNOWN;
                    res_c.last   = 1'b1;
                    phase_next   = PH_NORMAL;
                end else begin
                    phase_next      = PH_DROP;
                    error_code_next = ST_UNKNOWN;
                end
            end
            PH_HEX: begin
                high_nibble_next = 4'h0;
                if (is_hex) begin
                    has_res        = 1'b1;
                    res_c.out_byte = {high_nibble_reg, hv[3:0]};
                    res_c.last     = eos;
                    phase_next     = PH_NORMAL;
                end else if (eos) begin
                    has_res      = 1'b1;
                    res_c.status = ST_BADHEX;
                    res_c.last   = 1'b1;
                    phase_next   = PH_NORMAL;
                end else begin
                    phase_next      = PH_DROP;
                    error_code_next = ST_BADHEX;
                end
            end
            PH_DROP: begin
                // Drop everything until the end mark, then report the stored error.
                if (eos) begin
                    has_res         = 1'b1;
                    res_c.status    = error_code_reg;
                    res_c.last      = 1'b1;
                    phase_next      = PH_NORMAL;
                    error_code_next = ST_OK;
                end
            end
            default: begin
                phase_next = PH_NORMAL;
            end
        endcase
    end

    // Advance the item when it gives no result or the result register has room.
    assign item_take = item_valid && (!has_res || res_space);
    assign res_valid = item_valid && has_res && res_space;
    assign res       = res_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_NORMAL;
            high_nibble_reg <= 4'h0;
            error_code_reg  <= ST_OK;
        end else if (item_take) begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            error_code_reg  <= error_code_next;
        end
    end

    `ASSERT_IMPLIES(a_drop_has_code, aclk, aresetn,
                    phase_reg == PH_DROP, error_code_reg != ST_OK)
    `ASSERT_IMPLIES(a_code_only_drop, aclk, aresetn,
                    phase_reg != PH_DROP, error_code_reg == ST_OK)
    `ASSERT_IMPLIES(a_nibble_only_hex, aclk, aresetn,
                    phase_reg != PH_HEX, high_nibble_reg == 4'h0)
    `ASSERT_CLK(a_last_resets, aclk, aresetn,
                (item_take && res_valid && res.last) |=> (phase_reg == PH_NORMAL))

endmodule

// ----- src/backslash_escape_decoder.sv -----
// Top level of the backslash escape decoder: input stage, decoder and result register.
// Each accepted byte passes through the input register, then the decode logic into the
// result register. The block accepts one byte every cycle as long as results are taken;
// the update of the escape state as each byte is taken sets that rate. A byte yields at
// most one result; escape prefixes and bytes dropped after an error yield none, and the
// end-marked byte always yields exactly one result with last set. There are no
// configuration registers.
`include "assert_macros.svh"
module backslash_escape_decoder (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bed_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bed_pkg::out_t  m_data
);
    import bed_pkg::*;

    logic  item_valid;
    in_t   item;
    logic  item_take;
    logic  res_space;
    logic  res_valid;
    out_t  res;

    logic  m_valid_reg;
    logic  m_valid_next;
    out_t  m_data_reg;

    bed_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    bed_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_space  (res_space),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result register: room when empty or its transfer completes this cycle.
    assign res_space    = !m_valid_reg || m_ready;
    assign m_valid_next = res_valid || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_IMPLIES(a_err_zero_last, aclk, aresetn,
                    m_valid_reg && m_data_reg.status != ST_OK,
                    m_data_reg.out_byte == 8'h00 && m_data_reg.last)
    `ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, res_valid, !m_valid_reg || m_ready)

endmodule
